// File: rtl/scaled_alpha_image_blitter_macros.svh
// Assertion helpers used by the blitter top module.
`ifndef SCALED_ALPHA_IMAGE_BLITTER_MACROS_SVH
`define SCALED_ALPHA_IMAGE_BLITTER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SAB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("blitter check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SAB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("blitter check failed");

`endif

// File: rtl/sab_pkg.sv
package sab_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD_SRC = 2'd0,
    ACT_WRITE_FB = 2'd1,
    ACT_READ_FB  = 2'd2,
    ACT_BLIT     = 2'd3
  } sab_action_e;

  localparam logic [2:0] CFG_FB_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_FB_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_PITCH     = 3'd2;
  localparam logic [2:0] CFG_SRC_W     = 3'd3;
  localparam logic [2:0] CFG_SRC_H     = 3'd4;
  localparam logic [2:0] CFG_HAS_ALPHA = 3'd5;
  localparam logic [2:0] CFG_TOP_DOWN  = 3'd6;

  localparam int unsigned DimW  = 13;
  localparam int unsigned DivW  = DimW + 16;
  localparam logic [31:0] MaskRb = 32'h00FF_00FF;
  localparam logic [31:0] MaskG  = 32'h0000_FF00;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;
  localparam logic [7:0]  AlphaClear  = 8'h00;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] index;
    logic [31:0] pixel;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [12:0] target_width;
    logic [12:0] target_height;
  } sab_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        out_of_range;
  } sab_out_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DimW-1:0] divisor;
  } sab_div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } sab_div_rsp_t;

endpackage

// File: rtl/sab_div.sv
module sab_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sab_pkg::sab_div_req_t req_i,
  output sab_pkg::sab_div_rsp_t rsp_o
);
  import sab_pkg::*;

  // Restoring division, one quotient bit per cycle.
  logic            busy_q, done_q;
  logic [4:0]      cnt_q;
  logic [DimW-1:0] rem_q, div_q;
  logic [DivW-1:0] quo_q;
  logic [DimW:0]   trial;
  logic [DimW:0]   shifted;

  always_comb begin
    shifted = {rem_q, quo_q[DivW-1]};
    trial   = shifted - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!trial[DimW]) begin
        rem_q <= trial[DimW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DimW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: rtl/sab_mul.sv
module sab_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [15:0] b_i,
  output logic [31:0] p_o
);
  // Low word of the product, registered.
  logic [47:0] full;
  logic [31:0] p_q;

  assign full = a_i * {16'd0, b_i};

  always_ff @(posedge clk_i) begin
    p_q <= full[31:0];
  end

  assign p_o = p_q;

endmodule

// File: rtl/scaled_alpha_image_blitter.sv
// A load or frame-write item goes from idle straight to its result beat, a
// frame read through S_RD first. A blit runs the two ratio divisions in the
// shared divider, then S_ROW and S_ROWW per row and S_PIX up to S_G per
// target pixel, paced by the shared multiplier and the single-port store reads.
// One item is in flight at a time. Reset is asynchronous and active low; it
// clears control, config and result state, not item registers or the stores.
module scaled_alpha_image_blitter #(
  parameter int unsigned FRAME_WORDS  = 16384,
  parameter int unsigned SOURCE_WORDS = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sab_pkg::sab_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sab_pkg::sab_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);
  import sab_pkg::*;
  `include "scaled_alpha_image_blitter_macros.svh"

  localparam int unsigned FrAw = $clog2(FRAME_WORDS);
  localparam int unsigned SrAw = $clog2(SOURCE_WORDS);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DIVX, S_DIVY, S_ROW, S_ROWW, S_PIX, S_SX,
    S_SIDX, S_SRD, S_OFF, S_FRD, S_RB, S_G, S_RESP
  } state_e;

  state_e state_q;

  // Configuration registers. Writes must only be made while the block is idle; the block itself does not enforce this.
  logic [12:0] fb_w_q, fb_h_q, pitch_q, src_w_q, src_h_q;
  logic        has_alpha_q, top_down_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_w_q      <= '0;
      fb_h_q      <= '0;
      pitch_q     <= '0;
      src_w_q     <= 13'd1;
      src_h_q     <= 13'd1;
      has_alpha_q <= 1'b1;
      top_down_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FB_WIDTH:  fb_w_q      <= cfg_data_i[12:0];
        CFG_FB_HEIGHT: fb_h_q      <= cfg_data_i[12:0];
        CFG_PITCH:     pitch_q     <= cfg_data_i[12:0];
        CFG_SRC_W:     src_w_q     <= cfg_data_i[12:0];
        CFG_SRC_H:     src_h_q     <= cfg_data_i[12:0];
        CFG_HAS_ALPHA: has_alpha_q <= cfg_data_i[0];
        CFG_TOP_DOWN:  top_down_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Item fields held for the whole blit.
  logic [11:0] px_q, py_q;
  logic [12:0] tw_q, th_q;
  logic [31:0] xr_q, yr_q;
  logic [12:0] i_q, j_q;
  logic [15:0] sy_q, sx_q;
  logic [13:0] dy_q;
  logic [31:0] color_q, bg_q, rb_out_q, rd_q;
  logic [FrAw-1:0] off_q;
  logic        flag_q;

  logic accept;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Shared divider computes the two 16.16 ratios one after the other.
  sab_div_req_t div_req;
  sab_div_rsp_t div_rsp;

  sab_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    div_req = '0;
    if (state_q == S_IDLE && accept && in_data_i.action == ACT_BLIT &&
        in_data_i.target_width != '0 && in_data_i.target_height != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = {src_w_q, 16'd0};
      div_req.divisor  = in_data_i.target_width;
    end else if (state_q == S_DIVX && div_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = {src_h_q, 16'd0};
      div_req.divisor  = th_q;
    end
  end

  // Shared multiplier: every product of a pixel passes through it in turn.
  logic [31:0] mul_a, mul_p;
  logic [15:0] mul_b;
  logic [7:0]  alpha;
  logic [31:0] fr_rd_q;

  assign alpha = color_q[31:24];

  always_comb begin
    unique case (state_q)
      S_ROW: begin
        mul_a = yr_q;
        mul_b = {3'd0, i_q};
      end
      S_PIX: begin
        mul_a = xr_q;
        mul_b = {3'd0, j_q};
      end
      S_SX: begin
        mul_a = {19'd0, src_w_q};
        mul_b = sy_q;
      end
      S_SRD: begin
        mul_a = {19'd0, pitch_q};
        mul_b = {2'd0, dy_q};
      end
      S_FRD: begin
        mul_a = (color_q & MaskRb) - (fr_rd_q & MaskRb);
        mul_b = {8'd0, alpha};
      end
      S_RB: begin
        mul_a = (color_q & MaskG) - (bg_q & MaskG);
        mul_b = {8'd0, alpha};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  sab_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Per-pixel address arithmetic around the multiplier.
  logic [13:0] dy_c, dx_c;
  logic [31:0] sidx_c, off_c, src_color;
  logic        sidx_oob, off_oob, last_i, last_j;

  always_comb begin
    dy_c = top_down_q ? (14'(py_q) + 14'(i_q))
                      : (14'(py_q) + 14'(th_q - 13'd1 - i_q));
    dx_c      = 14'(px_q) + 14'(j_q);
    sidx_c    = mul_p + {16'd0, sx_q};
    off_c     = mul_p + {18'd0, dx_c};
    sidx_oob  = ({1'b0, sidx_c} >= 33'(SOURCE_WORDS));
    off_oob   = ({1'b0, off_c} >= 33'(FRAME_WORDS));
    last_i    = (i_q == th_q - 13'd1);
    last_j    = (j_q == tw_q - 13'd1);
  end

  // Source store: one write or one registered read a cycle.
  logic [31:0]     src_mem [SOURCE_WORDS];
  logic [31:0]     src_rd_q;
  logic [SrAw-1:0] src_addr;
  logic            src_we, idx_src_ok, idx_fr_ok;

  assign idx_src_ok = ({1'b0, in_data_i.index} < 17'(SOURCE_WORDS));
  assign idx_fr_ok  = ({1'b0, in_data_i.index} < 17'(FRAME_WORDS));
  assign src_we   = (state_q == S_IDLE) && accept &&
                    (in_data_i.action == ACT_LOAD_SRC) && idx_src_ok;
  assign src_addr = (state_q == S_IDLE) ? in_data_i.index[SrAw-1:0]
                                        : sidx_c[SrAw-1:0];

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[src_addr] <= in_data_i.pixel;
    end
    src_rd_q <= src_mem[src_addr];
  end

  assign src_color = has_alpha_q ? src_rd_q : {AlphaOpaque, src_rd_q[23:0]};

  // Frame store: host writes and reads, blit copies and read-modify-write.
  logic [31:0]     fr_mem [FRAME_WORDS];
  logic [31:0]     fr_wd, blend_c;
  logic [FrAw-1:0] fr_addr;
  logic            fr_we;

  assign blend_c = rb_out_q | (((mul_p >> 8) + (bg_q & MaskG)) & MaskG) |
                   {AlphaOpaque, 24'd0};

  always_comb begin
    fr_addr = off_q;
    fr_wd   = blend_c;
    fr_we   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        fr_addr = in_data_i.index[FrAw-1:0];
        fr_wd   = in_data_i.pixel;
        fr_we   = accept && (in_data_i.action == ACT_WRITE_FB) && idx_fr_ok;
      end
      S_OFF: begin
        fr_addr = off_c[FrAw-1:0];
        fr_wd   = color_q;
        fr_we   = !off_oob && (alpha == AlphaOpaque);
      end
      S_G: fr_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      fr_mem[fr_addr] <= fr_wd;
    end
    fr_rd_q <= fr_mem[fr_addr];
  end

  // Pixel and row stepping requests raised by the sequencer states.
  logic step_adv, row_adv, flag_set;

  always_comb begin
    step_adv = ((state_q == S_PIX)  && (dx_c >= 14'(fb_w_q))) ||
               ((state_q == S_SIDX) && sidx_oob) ||
               ((state_q == S_SRD)  && (src_color[31:24] == AlphaClear)) ||
               ((state_q == S_OFF)  && (off_oob || alpha == AlphaOpaque)) ||
               (state_q == S_G);
    row_adv  = (state_q == S_ROWW) && (dy_c >= 14'(fb_h_q));
    flag_set = ((state_q == S_SIDX) && sidx_oob) ||
               ((state_q == S_OFF) && off_oob);
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flag_q  <= 1'b0;
      rd_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      if (flag_set) begin
        flag_q <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            rd_q <= '0;
            px_q <= in_data_i.pos_x;
            py_q <= in_data_i.pos_y;
            tw_q <= in_data_i.target_width;
            th_q <= in_data_i.target_height;
            i_q  <= '0;
            j_q  <= '0;
            unique case (sab_action_e'(in_data_i.action))
              ACT_LOAD_SRC: begin
                flag_q  <= !idx_src_ok;
                state_q <= S_RESP;
              end
              ACT_WRITE_FB: begin
                flag_q  <= !idx_fr_ok;
                state_q <= S_RESP;
              end
              ACT_READ_FB: begin
                flag_q  <= !idx_fr_ok;
                state_q <= S_RD;
              end
              ACT_BLIT: begin
                flag_q  <= 1'b0;
                state_q <= (in_data_i.target_width == '0 ||
                            in_data_i.target_height == '0) ? S_RESP : S_DIVX;
              end
              default: state_q <= S_RESP;
            endcase
          end
        end
        S_RD: begin
          rd_q    <= flag_q ? '0 : fr_rd_q;
          state_q <= S_RESP;
        end
        S_DIVX: begin
          if (div_rsp.done) begin
            xr_q    <= 32'(div_rsp.quotient);
            state_q <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_rsp.done) begin
            yr_q    <= 32'(div_rsp.quotient);
            state_q <= S_ROW;
          end
        end
        S_ROW: state_q <= S_ROWW;
        S_ROWW: begin
          sy_q    <= mul_p[31:16];
          dy_q    <= dy_c;
          j_q     <= '0;
          state_q <= S_PIX;
        end
        S_PIX:  state_q <= S_SX;
        S_SX: begin
          sx_q    <= mul_p[31:16];
          state_q <= S_SIDX;
        end
        S_SIDX: state_q <= S_SRD;
        S_SRD: begin
          color_q <= src_color;
          state_q <= S_OFF;
        end
        S_OFF: begin
          off_q   <= off_c[FrAw-1:0];
          state_q <= S_FRD;
        end
        S_FRD: begin
          bg_q    <= fr_rd_q;
          state_q <= S_RB;
        end
        S_RB: begin
          rb_out_q <= ((mul_p >> 8) + (bg_q & MaskRb)) & MaskRb;
          state_q  <= S_G;
        end
        S_G: state_q <= S_PIX;
        S_RESP: begin
          if (!out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // Stepping to the next pixel or row overrides the plain transitions.
      if (row_adv || (step_adv && last_j)) begin
        if (last_i) begin
          state_q <= S_RESP;
        end else begin
          i_q     <= i_q + 13'd1;
          state_q <= S_ROW;
        end
      end else if (step_adv) begin
        j_q     <= j_q + 13'd1;
        state_q <= S_PIX;
      end
    end
  end

  assign out_valid_o             = (state_q == S_RESP);
  assign out_data_o.read_data    = rd_q;
  assign out_data_o.out_of_range = flag_q;

  // The divider only finishes while the sequencer waits for a ratio.
  `SAB_ASSERT_IMP(a_div_done_waited, div_rsp.done,
                  state_q == S_DIVX || state_q == S_DIVY)
  // A blit of zero width answers without stepping and without a flag.
  `SAB_ASSERT_NEXT(a_zero_blit_clean,
                   accept && in_data_i.action == ACT_BLIT &&
                   in_data_i.target_width == '0,
                   state_q == S_RESP && !flag_q && rd_q == '0)
  // The frame store is only written by an accepted write or by a blit pixel.
  `SAB_ASSERT_IMP(a_fr_write_source, fr_we,
                  accept || state_q == S_OFF || state_q == S_G)

endmodule
